/* rtl/rcpm_pkg.sv */
// Shared types, constants and a helper function for the run-class pattern matcher.
`default_nettype none

package rcpm_pkg;

   // Default longest pattern in class symbols.
   localparam int MAX_PATTERN_DEFAULT = 8;

   // Widths fixed by the register map and the stream payload.
   localparam int PIXEL_W       = 8;
   localparam int LEN_REG_W     = 4;
   localparam int SYM_REG_W     = 16;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int TDATA_IN_W    = 8;
   localparam int TDATA_OUT_W   = 8;
   localparam int CLASS_W       = 2;
   localparam int REG_SYM_COUNT = SYM_REG_W / CLASS_W;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_LENGTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_SYMBOLS = 1'b1;

   // Register reset values: pattern 1,3,2,3,1.
   localparam logic [LEN_REG_W-1:0] PATTERN_LENGTH_RESET  = 4'd5;
   localparam logic [SYM_REG_W-1:0] PATTERN_SYMBOLS_RESET = 16'd493;

   // Pixel class codes.
   localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_BLACK = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_GRAY  = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_WHITE = 2'd3;

   localparam logic [PIXEL_W-1:0] PIXEL_BLACK = 8'd0;
   localparam logic [PIXEL_W-1:0] PIXEL_GRAY  = 8'd128;
   localparam logic [PIXEL_W-1:0] PIXEL_WHITE = 8'd255;

   // Command handed to the matcher core with each pixel.
   typedef struct packed {
      logic                new_row;
      logic                run_start;
      logic [CLASS_W-1:0]  sym;
   } kmp_cmd_type;

   // Status returned by the matcher core.
   typedef struct packed {
      logic done;
      logic found;
      logic match_now;
   } kmp_status_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_RUN,
      TOP_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      KMP_IDLE,
      KMP_BUILD,
      KMP_BUILD_WAIT,
      KMP_MATCH,
      KMP_FALL_WAIT,
      KMP_FINAL_WAIT
   } kmp_state_type;

   function automatic logic [CLASS_W-1:0] class_of(input logic [PIXEL_W-1:0] value);
      logic [CLASS_W-1:0] result;
      unique case (value)
         PIXEL_BLACK: result = CLASS_BLACK;
         PIXEL_GRAY:  result = CLASS_GRAY;
         PIXEL_WHITE: result = CLASS_WHITE;
         default:     result = CLASS_OTHER;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

/* rtl/rcpm_kmp_core.sv */
// Pattern matcher core: failure-table build and search, table held in a synchronous memory.
`default_nettype none

module rcpm_kmp_core #(
   parameter int MAX_PATTERN = rcpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire rcpm_pkg::kmp_cmd_type                cmd,
   input  wire logic [rcpm_pkg::LEN_REG_W-1:0]       pattern_length,
   input  wire logic [rcpm_pkg::SYM_REG_W-1:0]       pattern_symbols,
   output      rcpm_pkg::kmp_status_type             status
);

   localparam int LW = $clog2(MAX_PATTERN + 1);
   localparam int IW = $clog2(MAX_PATTERN);
   localparam int PW = rcpm_pkg::CLASS_W * MAX_PATTERN;

   // Failure table memory, one port each for write and read.
   logic [IW-1:0] ft_mem [MAX_PATTERN];
   logic          ft_we;
   logic [IW-1:0] ft_waddr;
   logic [IW-1:0] ft_wdata;
   logic [IW-1:0] ft_raddr;
   logic [IW-1:0] ft_rdata_ff;

   rcpm_pkg::kmp_state_type state_ff, state_in;

   logic [PW-1:0]                   pat_ff, pat_in;
   logic [LW-1:0]                   pat_len_ff, pat_len_in;
   logic [LW-1:0]                   i_ff, i_in;
   logic [IW-1:0]                   t_ff, t_in;
   logic [LW-1:0]                   j_ff, j_in;
   logic [rcpm_pkg::CLASS_W-1:0]    sym_ff, sym_in;
   logic                            found_ff, found_in;
   logic                            now_ff, now_in;
   logic                            done_ff, done_in;

   logic [PW-1:0]                   pat_load;
   logic [LW-1:0]                   len_load;
   logic [rcpm_pkg::CLASS_W-1:0]    sym_i, sym_t, sym_j;
   logic [LW-1:0]                   j_next;

   // Symbols past the register read as class zero.
   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
      if (k < rcpm_pkg::REG_SYM_COUNT) begin : g_reg
         assign pat_load[rcpm_pkg::CLASS_W*k +: rcpm_pkg::CLASS_W] =
            pattern_symbols[rcpm_pkg::CLASS_W*k +: rcpm_pkg::CLASS_W];
      end else begin : g_zero
         assign pat_load[rcpm_pkg::CLASS_W*k +: rcpm_pkg::CLASS_W] = rcpm_pkg::CLASS_OTHER;
      end
   end

   always_comb begin
      if (pattern_length == '0) begin
         len_load = LW'(1);
      end else if (32'(pattern_length) > MAX_PATTERN) begin
         len_load = LW'(MAX_PATTERN);
      end else begin
         len_load = LW'(pattern_length);
      end
   end

   assign sym_i = pat_ff[{i_ff[IW-1:0], 1'b0} +: rcpm_pkg::CLASS_W];
   assign sym_t = pat_ff[{t_ff, 1'b0} +: rcpm_pkg::CLASS_W];
   assign sym_j = pat_ff[{j_ff[IW-1:0], 1'b0} +: rcpm_pkg::CLASS_W];
   assign j_next = j_ff + LW'(sym_j == sym_ff);

   always_comb begin
      state_in   = state_ff;
      pat_in     = pat_ff;
      pat_len_in = pat_len_ff;
      i_in       = i_ff;
      t_in       = t_ff;
      j_in       = j_ff;
      sym_in     = sym_ff;
      found_in   = found_ff;
      now_in     = now_ff;
      done_in    = 1'b0;
      ft_we      = 1'b0;
      ft_waddr   = '0;
      ft_wdata   = '0;
      ft_raddr   = '0;

      unique case (state_ff)
         rcpm_pkg::KMP_IDLE: begin
            if (start) begin
               now_in = 1'b0;
               sym_in = cmd.sym;
               if (cmd.new_row) begin
                  pat_in     = pat_load;
                  pat_len_in = len_load;
                  found_in   = 1'b0;
                  j_in       = '0;
                  i_in       = LW'(1);
                  t_in       = '0;
                  ft_we      = 1'b1;
                  ft_waddr   = '0;
                  ft_wdata   = '0;
                  state_in   = rcpm_pkg::KMP_BUILD;
               end else if (cmd.run_start) begin
                  if (j_ff >= pat_len_ff) begin
                     j_in = '0;
                  end
                  state_in = rcpm_pkg::KMP_MATCH;
               end else begin
                  done_in = 1'b1;
               end
            end
         end

         rcpm_pkg::KMP_BUILD: begin
            if (i_ff >= pat_len_ff) begin
               state_in = rcpm_pkg::KMP_MATCH;
            end else if (sym_i == sym_t) begin
               ft_we    = 1'b1;
               ft_waddr = i_ff[IW-1:0];
               ft_wdata = t_ff + 1'b1;
               t_in     = t_ff + 1'b1;
               i_in     = i_ff + 1'b1;
            end else if (t_ff != '0) begin
               ft_raddr = t_ff - 1'b1;
               state_in = rcpm_pkg::KMP_BUILD_WAIT;
            end else begin
               ft_we    = 1'b1;
               ft_waddr = i_ff[IW-1:0];
               ft_wdata = '0;
               i_in     = i_ff + 1'b1;
            end
         end

         rcpm_pkg::KMP_BUILD_WAIT: begin
            t_in     = ft_rdata_ff;
            state_in = rcpm_pkg::KMP_BUILD;
         end

         rcpm_pkg::KMP_MATCH: begin
            if (j_ff != '0 && sym_j != sym_ff) begin
               ft_raddr = IW'(j_ff - 1'b1);
               state_in = rcpm_pkg::KMP_FALL_WAIT;
            end else if (j_next >= pat_len_ff) begin
               // Full match: fall back so overlapping matches are still seen.
               now_in   = 1'b1;
               found_in = 1'b1;
               ft_raddr = IW'(pat_len_ff - 1'b1);
               state_in = rcpm_pkg::KMP_FINAL_WAIT;
            end else begin
               j_in     = j_next;
               done_in  = 1'b1;
               state_in = rcpm_pkg::KMP_IDLE;
            end
         end

         rcpm_pkg::KMP_FALL_WAIT: begin
            j_in     = LW'(ft_rdata_ff);
            state_in = rcpm_pkg::KMP_MATCH;
         end

         rcpm_pkg::KMP_FINAL_WAIT: begin
            j_in     = LW'(ft_rdata_ff);
            done_in  = 1'b1;
            state_in = rcpm_pkg::KMP_IDLE;
         end

         default: begin
            state_in = rcpm_pkg::KMP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ft_we) begin
         ft_mem[ft_waddr] <= ft_wdata;
      end
      ft_rdata_ff <= ft_mem[ft_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcpm_pkg::KMP_IDLE;
         j_ff     <= '0;
         found_ff <= 1'b0;
         now_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         found_ff <= found_in;
         now_ff   <= now_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff     <= pat_in;
      pat_len_ff <= pat_len_in;
      i_ff       <= i_in;
      t_ff       <= t_in;
      sym_ff     <= sym_in;
   end

   assign status.done      = done_ff;
   assign status.found     = found_ff;
   assign status.match_now = now_ff;

endmodule

`default_nettype wire

/* rtl/run_class_pattern_matcher_unit.sv */
// Top level of the run-class pattern matcher: stream handshake, run detection and result register.
`default_nettype none

// Each pixel of a row collapses with its run into a class symbol (0, 128, 255 or other) on the
// first pixel of the run, and the symbol is searched for the configured pattern with a
// Knuth-Morris-Pratt matcher whose failure table sits in a registered-read memory. One pixel
// is in work at a time and every pixel returns one result. A pixel that continues a run is
// answered from the idle state; a pixel that starts a run goes through the match state, with a
// wait state for each fallback through the failure table and another after a full match, since
// every table read waits on the memory. The first pixel of a row also builds the table from the
// pattern latched then. Register writes take effect with the next row. The next pixel is taken
// while a finished result still waits in the output register.
module run_class_pattern_matcher_unit #(
   parameter int MAX_PATTERN = rcpm_pkg::MAX_PATTERN_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Pixel stream.
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   input  wire logic [rcpm_pkg::TDATA_IN_W-1:0]      req_tdata,  // [7:0] pixel
   input  wire logic                                 req_tlast,  // last_pixel
   // Result stream.
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output      logic [rcpm_pkg::TDATA_OUT_W-1:0]     rsp_tdata,  // [0] found, [1] match_now
   output      logic                                 rsp_tlast,  // row_done
   // Register writes.
   input  wire logic                                 csr_we,
   input  wire logic [rcpm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [rcpm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   rcpm_pkg::top_state_type state_ff, state_in;

   logic [rcpm_pkg::LEN_REG_W-1:0]  len_reg_ff;
   logic [rcpm_pkg::SYM_REG_W-1:0]  sym_reg_ff;

   logic [rcpm_pkg::PIXEL_W-1:0]    prev_pixel_ff, prev_pixel_in;
   logic                            row_started_ff, row_started_in;
   logic                            last_ff, last_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic                            rsp_now_ff, rsp_now_in;
   logic                            rsp_last_ff, rsp_last_in;

   logic                            accept;
   logic                            out_free;
   logic [rcpm_pkg::PIXEL_W-1:0]    pixel;
   rcpm_pkg::kmp_cmd_type           cmd;
   rcpm_pkg::kmp_status_type        status;

   assign pixel    = req_tdata[rcpm_pkg::PIXEL_W-1:0];
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign cmd.new_row   = !row_started_ff;
   assign cmd.run_start = !row_started_ff || (pixel != prev_pixel_ff);
   assign cmd.sym       = rcpm_pkg::class_of(pixel);

   rcpm_kmp_core #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_kmp (
      .clock           (clock),
      .reset           (reset),
      .start           (accept),
      .cmd             (cmd),
      .pattern_length  (len_reg_ff),
      .pattern_symbols (sym_reg_ff),
      .status          (status)
   );

   always_comb begin
      state_in       = state_ff;
      prev_pixel_in  = prev_pixel_ff;
      row_started_in = row_started_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_now_in     = rsp_now_ff;
      rsp_last_in    = rsp_last_ff;
      req_tready     = 1'b0;

      unique case (state_ff)
         rcpm_pkg::TOP_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               last_in        = req_tlast;
               // The row's run tracking restarts after its last pixel.
               prev_pixel_in  = req_tlast ? '0 : pixel;
               row_started_in = !req_tlast;
               state_in       = rcpm_pkg::TOP_RUN;
            end
         end

         rcpm_pkg::TOP_RUN: begin
            if (status.done) begin
               state_in = out_free ? rcpm_pkg::TOP_IDLE : rcpm_pkg::TOP_EMIT;
            end
         end

         rcpm_pkg::TOP_EMIT: begin
            if (out_free) begin
               state_in = rcpm_pkg::TOP_IDLE;
            end
         end

         default: begin
            state_in = rcpm_pkg::TOP_IDLE;
         end
      endcase

      // The core holds its result until the next pixel starts it again.
      if (((state_ff == rcpm_pkg::TOP_RUN) && status.done) ||
          (state_ff == rcpm_pkg::TOP_EMIT)) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_found_in = status.found;
            rsp_now_in   = status.match_now;
            rsp_last_in  = last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rcpm_pkg::TOP_IDLE;
         len_reg_ff     <= rcpm_pkg::PATTERN_LENGTH_RESET;
         sym_reg_ff     <= rcpm_pkg::PATTERN_SYMBOLS_RESET;
         prev_pixel_ff  <= '0;
         row_started_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prev_pixel_ff  <= prev_pixel_in;
         row_started_ff <= row_started_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               rcpm_pkg::REG_PATTERN_LENGTH:
                  len_reg_ff <= csr_wdata[rcpm_pkg::LEN_REG_W-1:0];
               rcpm_pkg::REG_PATTERN_SYMBOLS:
                  sym_reg_ff <= csr_wdata[rcpm_pkg::SYM_REG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_now_ff   <= rsp_now_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rcpm_pkg::TDATA_OUT_W-2){1'b0}}, rsp_now_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the run-class pattern matcher: directed table, then random rows.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_PATTERN   = rcpm_pkg::MAX_PATTERN_DEFAULT;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int MAX_CYCLES    = 1000000;
   localparam int TAIL_CYCLES   = 60;

   typedef struct packed {
      logic found;
      logic match_now;
      logic row_done;
   } pixel_result_type;

   typedef enum logic {
      STEP_PIXEL,
      STEP_CSR
   } step_kind_type;

   typedef struct {
      step_kind_type                      kind;
      logic [rcpm_pkg::PIXEL_W-1:0]       pixel;
      logic                               last;
      logic [rcpm_pkg::CSR_INDEX_W-1:0]   index;
      logic [rcpm_pkg::CSR_DATA_W-1:0]    value;
      logic                               known;
      pixel_result_type                   want;
   } directed_step_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [rcpm_pkg::TDATA_IN_W-1:0]   req_tdata  = '0;  // [7:0] pixel
   logic                              req_tlast  = 1'b0; // last_pixel
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [rcpm_pkg::TDATA_OUT_W-1:0]  rsp_tdata;        // [0] found, [1] match_now
   logic                              rsp_tlast;        // row_done
   logic                              csr_we     = 1'b0;
   logic [rcpm_pkg::CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [rcpm_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   // Predictor state.
   logic [rcpm_pkg::LEN_REG_W-1:0]    cfg_length  = rcpm_pkg::PATTERN_LENGTH_RESET;
   logic [rcpm_pkg::SYM_REG_W-1:0]    cfg_symbols = rcpm_pkg::PATTERN_SYMBOLS_RESET;
   logic [rcpm_pkg::PIXEL_W-1:0]      prev_pixel  = '0;
   logic                              in_row      = 1'b0;
   logic                              found_flag  = 1'b0;
   int                                matched     = 0;
   int                                act_len     = 0;
   logic [rcpm_pkg::CLASS_W-1:0]      act_pattern [0:MAX_PATTERN-1];
   int                                fallback    [0:MAX_PATTERN-1];

   pixel_result_type                  expected_results [$];
   directed_step_type                 directed_steps [$];
   logic [rcpm_pkg::PIXEL_W-1:0]      row_pixels [$];
   int                                error_count = 0;
   int                                items_sent  = 0;
   int                                cycle_count = 0;
   logic                              calm        = 1'b0;
   int unsigned                       rx_stall    = 0;

   run_class_pattern_matcher_unit #(
      .MAX_PATTERN(MAX_PATTERN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == MAX_CYCLES) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   function automatic logic [rcpm_pkg::CLASS_W-1:0] pixel_class(
      input logic [rcpm_pkg::PIXEL_W-1:0] px);
      if (px == rcpm_pkg::PIXEL_BLACK) return rcpm_pkg::CLASS_BLACK;
      if (px == rcpm_pkg::PIXEL_GRAY) return rcpm_pkg::CLASS_GRAY;
      if (px == rcpm_pkg::PIXEL_WHITE) return rcpm_pkg::CLASS_WHITE;
      return rcpm_pkg::CLASS_OTHER;
   endfunction

   // Steps the matcher model by one pixel and returns the result it gives.
   function automatic pixel_result_type predict_pixel(input logic [rcpm_pkg::PIXEL_W-1:0] px,
                                                      input logic last);
      pixel_result_type res;
      logic run_start;
      logic now;
      logic [rcpm_pkg::CLASS_W-1:0] sym;
      int len, i, t, j, k;
      now = 1'b0;
      if (!in_row) begin
         // The pattern and its failure table are latched on the row's first pixel.
         len = int'(cfg_length);
         if (len < 1) len = 1;
         if (len > MAX_PATTERN) len = MAX_PATTERN;
         act_len = len;
         for (k = 0; k < MAX_PATTERN; k++) begin
            act_pattern[k] = (k < rcpm_pkg::REG_SYM_COUNT) ? cfg_symbols[2*k +: 2] :
                                                             rcpm_pkg::CLASS_OTHER;
         end
         fallback[0] = 0;
         t = 0;
         i = 1;
         while (i < len) begin
            if (act_pattern[i] == act_pattern[t]) begin
               t++;
               fallback[i] = t;
               i++;
            end else if (t != 0) begin
               t = fallback[t-1];
            end else begin
               fallback[i] = 0;
               i++;
            end
         end
         matched = 0;
         found_flag = 1'b0;
         run_start = 1'b1;
         in_row = 1'b1;
      end else begin
         run_start = (px != prev_pixel);
      end
      if (run_start) begin
         sym = pixel_class(px);
         j = matched;
         if (j >= act_len) j = 0;
         while (j > 0 && act_pattern[j] != sym) j = fallback[j-1];
         if (act_pattern[j] == sym) j++;
         if (j >= act_len) begin
            now = 1'b1;
            found_flag = 1'b1;
            j = fallback[act_len-1];
         end
         matched = j;
      end
      prev_pixel = px;
      res.found = found_flag;
      res.match_now = now;
      res.row_done = last;
      if (last) begin
         prev_pixel = '0;
         in_row = 1'b0;
         matched = 0;
         found_flag = 1'b0;
      end
      return res;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [rcpm_pkg::PIXEL_W-1:0] random_pixel();
      case ($urandom_range(0, 4))
         0: return rcpm_pkg::PIXEL_BLACK;
         1: return rcpm_pkg::PIXEL_GRAY;
         2: return rcpm_pkg::PIXEL_WHITE;
         default: return rcpm_pkg::PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_pixel(input logic [rcpm_pkg::PIXEL_W-1:0] px, input logic last);
      directed_step_type s;
      s = '{STEP_PIXEL, px, last, '0, '0, 1'b0, '0};
      directed_steps.push_back(s);
   endfunction

   function automatic void add_known(input logic [rcpm_pkg::PIXEL_W-1:0] px, input logic last,
                                     input logic found, input logic match_now);
      directed_step_type s;
      s = '{STEP_PIXEL, px, last, '0, '0, 1'b1, '{found, match_now, last}};
      directed_steps.push_back(s);
   endfunction

   function automatic void add_csr(input logic [rcpm_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [rcpm_pkg::CSR_DATA_W-1:0] val);
      directed_step_type s;
      s = '{STEP_CSR, '0, 1'b0, idx, val, 1'b0, '0};
      directed_steps.push_back(s);
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("tb_top: mismatch in %s at cycle %0d: expected %0h, got %0h",
               what, cycle_count, want, got);
      error_count++;
   endtask

   // Presents one pixel and records its expected result once the transfer happens.
   task automatic send_pixel(input logic [rcpm_pkg::PIXEL_W-1:0] px, input logic last,
                             input logic known, input pixel_result_type want);
      int unsigned gap;
      pixel_result_type res;
      gap = pick_gap();
      if (csr_we) csr_we <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      res = predict_pixel(px, last);
      expected_results.push_back(known ? want : res);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      csr_we <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic csr_write(input logic [rcpm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [rcpm_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == rcpm_pkg::REG_PATTERN_LENGTH) cfg_length = val[rcpm_pkg::LEN_REG_W-1:0];
      else cfg_symbols = val;
   endtask

   always @(posedge clock) begin : rx_backpressure
      int unsigned g;
      if (rx_stall != 0) begin
         rx_stall <= rx_stall - 1;
      end else begin
         g = pick_gap();
         if (g != 0) begin
            rsp_tready <= 1'b0;
            rx_stall <= g - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 0, 32'({rsp_tlast, rsp_tdata}));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[0] !== want.found)
               report_mismatch("found", 32'(want.found), 32'(rsp_tdata[0]));
            if (rsp_tdata[1] !== want.match_now)
               report_mismatch("match_now", 32'(want.match_now), 32'(rsp_tdata[1]));
            if (rsp_tlast !== want.row_done)
               report_mismatch("row_done", 32'(want.row_done), 32'(rsp_tlast));
            if (rsp_tdata[rcpm_pkg::TDATA_OUT_W-1:2] !== '0)
               report_mismatch("tdata padding", 0,
                               32'(rsp_tdata[rcpm_pkg::TDATA_OUT_W-1:2]));
         end
      end
   end

   initial begin : stimulus
      directed_step_type s;
      logic [rcpm_pkg::PIXEL_W-1:0] px;
      logic [rcpm_pkg::CLASS_W-1:0] sym, cls_a, cls_b;
      logic [rcpm_pkg::SYM_REG_W-1:0] new_symbols;
      logic [rcpm_pkg::LEN_REG_W-1:0] new_len;
      int random_items, budget, parts, plen, reps, len, k, pick;

      // Reset pattern is 1,3,2,3,1, that is the pixels 0, 255, 128, 255, 0.
      add_known(8'd7, 1'b0, 1'b0, 1'b0);
      add_known(8'd7, 1'b1, 1'b0, 1'b0);
      add_known(rcpm_pkg::PIXEL_BLACK, 1'b0, 1'b0, 1'b0);
      add_known(rcpm_pkg::PIXEL_WHITE, 1'b0, 1'b0, 1'b0);
      add_known(rcpm_pkg::PIXEL_GRAY, 1'b0, 1'b0, 1'b0);
      add_known(rcpm_pkg::PIXEL_WHITE, 1'b0, 1'b0, 1'b0);
      add_known(rcpm_pkg::PIXEL_BLACK, 1'b1, 1'b1, 1'b1);
      // Overlapping matches, with a run that must not count twice.
      add_pixel(rcpm_pkg::PIXEL_BLACK, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_WHITE, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_WHITE, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_GRAY, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_WHITE, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_BLACK, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_WHITE, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_GRAY, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_WHITE, 1'b0);
      add_pixel(rcpm_pkg::PIXEL_BLACK, 1'b1);
      // Single-symbol pattern, then a zero length that acts as one.
      add_csr(rcpm_pkg::REG_PATTERN_LENGTH, 16'd1);
      add_csr(rcpm_pkg::REG_PATTERN_SYMBOLS, 16'h0001);
      add_known(rcpm_pkg::PIXEL_BLACK, 1'b1, 1'b1, 1'b1);
      add_csr(rcpm_pkg::REG_PATTERN_LENGTH, 16'd0);
      add_known(rcpm_pkg::PIXEL_BLACK, 1'b1, 1'b1, 1'b1);
      // A length above the maximum is clipped; all-white cannot match.
      add_csr(rcpm_pkg::REG_PATTERN_LENGTH, 16'hFFFF);
      add_csr(rcpm_pkg::REG_PATTERN_SYMBOLS, 16'hFFFF);
      add_known(rcpm_pkg::PIXEL_WHITE, 1'b1, 1'b0, 1'b0);
      // A write in the middle of a row only takes effect with the next row.
      add_csr(rcpm_pkg::REG_PATTERN_LENGTH, 16'd2);
      add_csr(rcpm_pkg::REG_PATTERN_SYMBOLS, 16'h0000);
      add_known(8'd5, 1'b0, 1'b0, 1'b0);
      add_csr(rcpm_pkg::REG_PATTERN_LENGTH, 16'd1);
      add_csr(rcpm_pkg::REG_PATTERN_SYMBOLS, 16'h0002);
      add_known(8'd6, 1'b1, 1'b1, 1'b1);
      add_known(rcpm_pkg::PIXEL_GRAY, 1'b1, 1'b1, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[n]) begin
         s = directed_steps[n];
         if (s.kind == STEP_CSR) begin
            drain_results();
            csr_write(s.index, s.value);
         end else begin
            send_pixel(s.pixel, s.last, s.known, s.want);
         end
      end

      // Random phases; a phase may end in the middle of a row.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_results();
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            case ($urandom_range(0, 3))
               0: new_len = 4'd0;
               1: new_len = 4'd1;
               2: new_len = 4'd8;
               default: new_len = 4'd15;
            endcase
         end else if (pick < 3) begin
            new_len = rcpm_pkg::LEN_REG_W'($urandom_range(9, 15));
         end else begin
            new_len = rcpm_pkg::LEN_REG_W'($urandom_range(1, 8));
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            new_symbols = '0;
         end else if (pick == 1) begin
            new_symbols = '1;
         end else if (pick < 6) begin
            // Two classes only, so the pattern overlaps itself a lot.
            cls_a = rcpm_pkg::CLASS_W'($urandom_range(0, 3));
            cls_b = rcpm_pkg::CLASS_W'($urandom_range(0, 3));
            for (k = 0; k < rcpm_pkg::REG_SYM_COUNT; k++) begin
               new_symbols[2*k +: 2] = ($urandom_range(0, 1) != 0) ? cls_a : cls_b;
            end
         end else begin
            new_symbols = rcpm_pkg::SYM_REG_W'($urandom());
         end
         pick = $urandom_range(0, 4);
         if (pick != 1) begin
            csr_write(rcpm_pkg::REG_PATTERN_LENGTH,
                      {(rcpm_pkg::CSR_DATA_W-rcpm_pkg::LEN_REG_W)'($urandom()), new_len});
         end
         if (pick != 0) csr_write(rcpm_pkg::REG_PATTERN_SYMBOLS, new_symbols);
         calm = ($urandom_range(0, 4) == 0);
         budget = $urandom_range(20, 160);
         if (budget > RANDOM_ITEMS - random_items) budget = RANDOM_ITEMS - random_items;
         repeat (budget) begin
            if (row_pixels.size() == 0) begin
               if ($urandom_range(0, 3) != 0) begin
                  // Rows built from copies of the pattern mixed with noise runs.
                  parts = $urandom_range(1, 4);
                  repeat (parts) begin
                     if ($urandom_range(0, 2) != 0) begin
                        plen = int'(cfg_length);
                        if (plen < 1) plen = 1;
                        if (plen > MAX_PATTERN) plen = MAX_PATTERN;
                        for (k = 0; k < plen; k++) begin
                           sym = cfg_symbols[2*k +: 2];
                           case (sym)
                              rcpm_pkg::CLASS_BLACK: px = rcpm_pkg::PIXEL_BLACK;
                              rcpm_pkg::CLASS_GRAY:  px = rcpm_pkg::PIXEL_GRAY;
                              rcpm_pkg::CLASS_WHITE: px = rcpm_pkg::PIXEL_WHITE;
                              default: begin
                                 do px = rcpm_pkg::PIXEL_W'($urandom_range(1, 254));
                                 while (px == rcpm_pkg::PIXEL_GRAY);
                              end
                           endcase
                           reps = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
                           repeat (reps) row_pixels.push_back(px);
                        end
                     end else begin
                        px = random_pixel();
                        reps = $urandom_range(1, 3);
                        repeat (reps) row_pixels.push_back(px);
                     end
                  end
               end else begin
                  len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
                  repeat (len) row_pixels.push_back(random_pixel());
               end
            end
            px = row_pixels.pop_front();
            send_pixel(px, row_pixels.size() == 0, 1'b0, '0);
            random_items++;
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
